/* src/psp_pkg.sv */
package psp_pkg;

  localparam int ADDR_W      = 48;
  localparam int OCC_W       = 9;
  localparam int TAG_W       = 32;
  localparam int WIN_W       = 7;
  localparam int CONF_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 80;

  localparam logic [CONF_W-1:0] CONF_MAX = 8'd255;

  localparam logic [WIN_W-1:0]  WINDOW_RST   = 7'd16;
  localparam logic [CONF_W-1:0] CONF_THR_RST = 8'd2;
  localparam logic [OCC_W-1:0]  OCC_THR_RST  = 9'd128;

  // two's complement direction codes
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_THR       = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOKUP = 6'b000010,
    S_PICK   = 6'b000100,
    S_TRAIN  = 6'b001000,
    S_EMIT   = 6'b010000,
    S_STORE  = 6'b100000
  } psp_state_t;

  typedef struct packed {
    logic load;    // capture an accepted request
    logic lookup;  // register the page match vector
    logic pick;    // select the entry and load the working copy
    logic train;   // update direction and confidence
    logic step;    // advance the pointer, maybe emit
    logic store;   // write the working copy back to the table
  } psp_cmd_t;

  typedef struct packed {
    logic go;        // confidence meets threshold after training
    logic out_free;  // output register can take a result
    logic run_done;  // the current step ends the run
  } psp_status_t;

endpackage

/* src/psp_ctrl.sv */
module psp_ctrl
  import psp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  psp_status_t sts,
  output psp_cmd_t    cmd
);

  psp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE) || (state_r == S_STORE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_TRAIN;
      end
      S_TRAIN: begin
        cmd.train = 1'b1;
        state_nxt = sts.go ? S_EMIT : S_STORE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.run_done) begin
            state_nxt = S_STORE;
          end
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOKUP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/psp_datapath.sv */
module psp_datapath
  import psp_pkg::*;
#(
  parameter int NUM_STREAMS = 16,
  parameter int MAX_DEGREE  = 4,
  parameter int PAGE_BITS   = 12,
  parameter int BLOCK_BITS  = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psp_cmd_t              cmd,
  output psp_status_t           sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ADDR_W-1:0]     access_address,
  input  logic [OCC_W-1:0]      queue_occupancy,
  input  logic [TAG_W-1:0]      tag_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     prefetch_address,
  output logic                  fill_near,
  output logic [TAG_W-1:0]      tag_out,
  output logic                  last_of_run
);

  localparam int PG_W        = ADDR_W - PAGE_BITS;
  localparam int OFS_W       = PAGE_BITS - BLOCK_BITS;
  localparam int PAGE_BLOCKS = 1 << OFS_W;
  // room for a pointer that has run well past the page in either direction
  localparam int PTR_W       = ((OFS_W > WIN_W) ? OFS_W : WIN_W) + 2;
  localparam int DIFF_W      = PTR_W + 1;
  localparam int CMP_W       = (DIFF_W > WIN_W) ? DIFF_W : WIN_W;
  localparam int IDX_W       = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int CNT_W       = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  // configuration
  logic [WIN_W-1:0]  window_r;
  logic [CONF_W-1:0] conf_thr_r;
  logic [OCC_W-1:0]  occ_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RST;
      conf_thr_r <= CONF_THR_RST;
      occ_thr_r  <= OCC_THR_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_STREAM_WINDOW: window_r   <= cfg_data[WIN_W-1:0];
        CFG_CONF_THR:      conf_thr_r <= cfg_data[CONF_W-1:0];
        CFG_OCC_THR:       occ_thr_r  <= cfg_data[OCC_W-1:0];
        default:           ;
      endcase
    end
  end

  // stream table
  logic [PG_W-1:0]   page_r [NUM_STREAMS];
  logic [1:0]        dir_r  [NUM_STREAMS];
  logic [CONF_W-1:0] conf_r [NUM_STREAMS];
  logic [PTR_W-1:0]  ptr_r  [NUM_STREAMS];
  logic [IDX_W-1:0]  victim_r;

  // request and working copy
  logic [PG_W-1:0]        acc_page_r;
  logic [OFS_W-1:0]       ofs_r;
  logic [OCC_W-1:0]       occ_r;
  logic [TAG_W-1:0]       tag_r;
  logic [NUM_STREAMS-1:0] hit_vec_r;
  logic [IDX_W-1:0]       ent_r;
  logic [1:0]             wdir_r;
  logic [CONF_W-1:0]      wconf_r;
  logic [PTR_W-1:0]       wptr_r;
  logic [CNT_W-1:0]       cnt_r;

  // output register
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_near_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic              out_last_r;

  function automatic logic [PTR_W-1:0] step_sat(input logic [PTR_W-1:0] ptr,
                                                input logic [1:0] d);
    logic [PTR_W:0] s;
    logic [PTR_W-1:0] res;
    s = {ptr[PTR_W-1], ptr} + {{(PTR_W-1){d[1]}}, d};
    if (s[PTR_W] != s[PTR_W-1]) begin
      res = s[PTR_W] ? {1'b1, {(PTR_W-1){1'b0}}} : {1'b0, {(PTR_W-1){1'b1}}};
    end else begin
      res = s[PTR_W-1:0];
    end
    return res;
  endfunction

  function automatic logic in_page(input logic [PTR_W-1:0] p);
    return !p[PTR_W-1] && (p[PTR_W-2:0] < (PTR_W-1)'(PAGE_BLOCKS));
  endfunction

  // match vector, one comparator per entry
  logic [NUM_STREAMS-1:0] hit_vec;
  always_comb begin
    for (int i = 0; i < NUM_STREAMS; i++) begin
      hit_vec[i] = (page_r[i] == acc_page_r);
    end
  end

  // lowest matching entry wins
  logic [IDX_W-1:0] hit_idx;
  always_comb begin
    hit_idx = '0;
    for (int i = NUM_STREAMS - 1; i >= 0; i--) begin
      if (hit_vec_r[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end
  logic hit;
  assign hit = |hit_vec_r;

  // training
  logic [DIFF_W-1:0] diff, mag;
  logic              pos, neg, win_ok, trn;
  logic [1:0]        nd, opp, dir_t;
  logic [CONF_W-1:0] conf_t;
  always_comb begin
    diff   = DIFF_W'(ofs_r) - {wptr_r[PTR_W-1], wptr_r};
    neg    = diff[DIFF_W-1];
    pos    = !neg && (diff != '0);
    mag    = neg ? (DIFF_W'(0) - diff) : diff;
    win_ok = CMP_W'(mag) < CMP_W'(window_r);
    trn    = (pos || neg) && win_ok;
    nd     = pos ? DIR_UP : DIR_DOWN;
    opp    = pos ? DIR_DOWN : DIR_UP;
    dir_t  = trn ? nd : wdir_r;
    conf_t = wconf_r;
    if (trn) begin
      if (wdir_r == opp) begin
        conf_t = '0;
      end else if (wconf_r != CONF_MAX) begin
        conf_t = wconf_r + CONF_W'(1);
      end
    end
  end

  // pointer step with one step of look-ahead for the end of the run
  logic [PTR_W-1:0] p1, p2;
  logic             emit, cnt_end, last;
  assign p1      = step_sat(wptr_r, wdir_r);
  assign p2      = step_sat(p1, wdir_r);
  assign emit    = in_page(p1);
  assign cnt_end = (cnt_r == CNT_W'(MAX_DEGREE - 1));
  assign last    = cnt_end || !in_page(p2);

  assign sts.go       = (conf_t >= conf_thr_r);
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.run_done = !emit || last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STREAMS; i++) begin
        page_r[i] <= '0;
        dir_r[i]  <= DIR_NONE;
        conf_r[i] <= '0;
        ptr_r[i]  <= '1;
      end
      victim_r <= '0;
    end else begin
      if (cmd.pick && !hit) begin
        victim_r <= (victim_r == IDX_W'(NUM_STREAMS - 1)) ? '0 : victim_r + IDX_W'(1);
      end
      if (cmd.store) begin
        page_r[ent_r] <= acc_page_r;
        dir_r[ent_r]  <= wdir_r;
        conf_r[ent_r] <= wconf_r;
        ptr_r[ent_r]  <= wptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_page_r <= access_address[ADDR_W-1:PAGE_BITS];
      ofs_r      <= access_address[PAGE_BITS-1:BLOCK_BITS];
      occ_r      <= queue_occupancy;
      tag_r      <= tag_word;
    end
    if (cmd.lookup) begin
      hit_vec_r <= hit_vec;
    end
    if (cmd.pick) begin
      cnt_r <= '0;
      if (hit) begin
        ent_r   <= hit_idx;
        wdir_r  <= dir_r[hit_idx];
        wconf_r <= conf_r[hit_idx];
        wptr_r  <= ptr_r[hit_idx];
      end else begin
        ent_r   <= victim_r;
        wdir_r  <= DIR_NONE;
        wconf_r <= '0;
        wptr_r  <= PTR_W'(ofs_r);
      end
    end
    if (cmd.train) begin
      wdir_r  <= dir_t;
      wconf_r <= conf_t;
    end
    if (cmd.step) begin
      cnt_r <= cnt_r + CNT_W'(1);
      // a run cut short at the page edge leaves the pointer outside it
      wptr_r <= (emit && !cnt_end && !in_page(p2)) ? p2 : p1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      out_addr_r <= {acc_page_r, p1[OFS_W-1:0], {BLOCK_BITS{1'b0}}};
      out_near_r <= (occ_r < occ_thr_r);
      out_tag_r  <= tag_r;
      out_last_r <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign prefetch_address = out_addr_r;
  assign fill_near        = out_near_r;
  assign tag_out          = out_tag_r;
  assign last_of_run      = out_last_r;

endmodule

/* src/page_stream_prefetcher.sv */
// Path: after acceptance a request passes the lookup, pick and training states, then the
//   emit state takes one pointer step per result (n results need n steps, at least one when
//   confidence is met) into the single output register, which drains one result per cycle
//   while out_tready is high; the next request is taken only in the store state or idle.
// Reset: synchronous, active low; clears the stream table (pointers to minus one), the
//   victim pointer, the controller and the output valid, and loads the register defaults.
module page_stream_prefetcher
  import psp_pkg::*;
#(
  parameter int NUM_STREAMS = 16,
  parameter int MAX_DEGREE  = 4,
  parameter int PAGE_BITS   = 12,
  parameter int BLOCK_BITS  = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // access_address [47:0], queue_occupancy [56:48], tag_word [88:57], zero [95:89]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // prefetch channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // prefetch_address [47:0], tag_out [79:48]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // fill_near [0]
  output logic                   out_tuser,
  output logic                   out_tlast
);

  psp_cmd_t    cmd;
  psp_status_t sts;

  logic [ADDR_W-1:0] prefetch_address;
  logic [TAG_W-1:0]  tag_out;

  // Controller: sequences lookup, pick, training, the emit loop and the store per request.
  psp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: configuration registers, stream table, working copy of one entry, and the output register.
  psp_datapath #(
    .NUM_STREAMS (NUM_STREAMS),
    .MAX_DEGREE  (MAX_DEGREE),
    .PAGE_BITS   (PAGE_BITS),
    .BLOCK_BITS  (BLOCK_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data),
    .access_address   (in_tdata[ADDR_W-1:0]),
    .queue_occupancy  (in_tdata[ADDR_W+OCC_W-1:ADDR_W]),
    .tag_word         (in_tdata[ADDR_W+OCC_W+TAG_W-1:ADDR_W+OCC_W]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .prefetch_address (prefetch_address),
    .fill_near        (out_tuser),
    .tag_out          (tag_out),
    .last_of_run      (out_tlast)
  );

  // pack the result: address low, metadata above
  assign out_tdata = {tag_out, prefetch_address};

endmodule

/* src/psp_checker.sv */
module psp_checker
  import psp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("result changed while stalled");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // one request in work at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken during lookup");

  // no result can appear straight after a request is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared before lookup");

endmodule

bind page_stream_prefetcher psp_checker u_psp_checker (.*);
